### hw/rtl/weighted_random_select_table_unit_assert.svh
// assertion macros for the checker file of the selection table unit
`ifndef WEIGHTED_RANDOM_SELECT_TABLE_UNIT_ASSERT_SVH
`define WEIGHTED_RANDOM_SELECT_TABLE_UNIT_ASSERT_SVH

// clocked property, switched off while reset is high
`define WRST_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("wrst assertion failed");

// clocked property that also holds through reset
`define WRST_ASSERT_NORST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("wrst assertion failed");

`endif

### hw/rtl/wrst_pkg.sv
// types, constants and helpers of the weighted selection table unit
package wrst_pkg;

   localparam int MAX_ENTRIES = 16;
   localparam int WEIGHT_BITS = 16;
   localparam int TYPE_BITS   = 8;

   localparam int OPCODE_W = 2;
   localparam int CHANCE_W = 7;
   localparam int DRAW_W   = 20;
   localparam int SUM_W    = 20;
   localparam int COUNT_W  = 5;
   localparam int STATUS_W = 2;

   localparam int COUNT_BITS = $clog2(MAX_ENTRIES + 1);
   localparam int IDX_BITS   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int ACC_W      = WEIGHT_BITS + COUNT_BITS;
   localparam int CMP_W      = ((ACC_W > DRAW_W) ? ACC_W : DRAW_W) + 1;
   localparam int SAT_W      = ((SUM_W > WEIGHT_BITS) ? SUM_W : WEIGHT_BITS) + 1;

   localparam logic [CHANCE_W-1:0] PCT_RESET = CHANCE_W'(100);
   localparam logic [SUM_W-1:0]    SUM_MAX   = '1;

   // request tdata layout
   localparam int REQ_TYPE_LSB   = 0;
   localparam int REQ_WEIGHT_LSB = REQ_TYPE_LSB + TYPE_BITS;
   localparam int REQ_CHANCE_LSB = REQ_WEIGHT_LSB + WEIGHT_BITS;
   localparam int REQ_DRAW_LSB   = REQ_CHANCE_LSB + CHANCE_W;
   localparam int REQ_BITS       = REQ_DRAW_LSB + DRAW_W;
   localparam int REQ_TDATA_W    = ((REQ_BITS + 7) / 8) * 8;

   // response tdata layout
   localparam int RSP_DROP_LSB  = 0;
   localparam int RSP_TYPE_LSB  = RSP_DROP_LSB + 1;
   localparam int RSP_COUNT_LSB = RSP_TYPE_LSB + TYPE_BITS;
   localparam int RSP_SUM_LSB   = RSP_COUNT_LSB + COUNT_W;
   localparam int RSP_BITS      = RSP_SUM_LSB + SUM_W;
   localparam int RSP_TDATA_W   = ((RSP_BITS + 7) / 8) * 8;

   typedef enum logic [OPCODE_W-1:0] {
      OP_ADD    = 2'd0,
      OP_CLEAR  = 2'd1,
      OP_REMOVE = 2'd2,
      OP_ROLL   = 2'd3
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_DONE   = 2'd0,
      STAT_ZERO   = 2'd1,
      STAT_FULL   = 2'd2,
      STAT_NODROP = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_WALK,
      FSM_FINISH
   } state_type;

   typedef struct packed {
      logic accept;
      logic step;
      logic finish;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic walk_needed;
      logic walk_done;
   } dp_status_type;

   function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                input logic [WEIGHT_BITS-1:0] b);
      logic [SAT_W-1:0] s;
      s = SAT_W'(a) + SAT_W'(b);
      return (s > SAT_W'(SUM_MAX)) ? SUM_MAX : s[SUM_W-1:0];
   endfunction

endpackage

### hw/rtl/wrst_ctrl.sv
// control state machine: request acceptance, table walk sequencing, response valid
module wrst_ctrl
   import wrst_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  dp_status_type dp_status,
   output cmd_type       cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      req_tready   = 1'b0;
      cmd          = '0;
      case (state_ff)
         FSM_IDLE: begin
            req_tready = out_free;
         end
         FSM_WALK: begin
            cmd.step = !dp_status.walk_done;
         end
         FSM_FINISH: begin
            cmd.finish = out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
      cmd.accept   = req_tvalid && req_tready;
      cmd.load_rsp = (cmd.accept && !dp_status.walk_needed) || cmd.finish;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (req_tvalid && req_tready && dp_status.walk_needed) begin
               state_in = FSM_WALK;
            end
         end
         FSM_WALK: begin
            if (dp_status.walk_done) begin
               state_in = FSM_FINISH;
            end
         end
         FSM_FINISH: begin
            if (out_free) begin
               state_in = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### hw/rtl/wrst_dpath.sv
// datapath: entry table, count and sum, percent register, walk registers, response register
module wrst_dpath
   import wrst_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wen,
   input  logic [CHANCE_W-1:0]    csr_wdata,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [OPCODE_W-1:0]    req_tuser,
   input  cmd_type                cmd,
   output dp_status_type          dp_status,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic [STATUS_W-1:0]    rsp_tuser
);

   logic [TYPE_BITS-1:0]   types_ff   [MAX_ENTRIES];
   logic [WEIGHT_BITS-1:0] weights_ff [MAX_ENTRIES];

   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [CHANCE_W-1:0]    pct_ff, pct_in;

   opcode_type             op_ff, op_in;
   logic [TYPE_BITS-1:0]   type_ff, type_in;
   logic [DRAW_W-1:0]      draw_ff, draw_in;
   logic [COUNT_BITS-1:0]  idx_ff, idx_in;
   logic [COUNT_BITS-1:0]  keep_ff, keep_in;
   logic [ACC_W-1:0]       acc_ff, acc_in;
   logic [SUM_W-1:0]       newsum_ff, newsum_in;
   logic                   hit_ff, hit_in;
   logic [TYPE_BITS-1:0]   hit_type_ff, hit_type_in;

   logic                   drop_ff, drop_in;
   logic [TYPE_BITS-1:0]   out_type_ff, out_type_in;
   status_type             out_stat_ff, out_stat_in;
   logic [COUNT_BITS-1:0]  out_count_ff, out_count_in;
   logic [SUM_W-1:0]       out_sum_ff, out_sum_in;

   logic                   wr_en;
   logic [IDX_BITS-1:0]    wr_idx;
   logic [TYPE_BITS-1:0]   wr_type;
   logic [WEIGHT_BITS-1:0] wr_weight;

   opcode_type             req_op;
   logic [TYPE_BITS-1:0]   req_type;
   logic [WEIGHT_BITS-1:0] req_weight;
   logic [CHANCE_W-1:0]    req_chance;
   logic [DRAW_W-1:0]      req_draw;
   logic                   roll_pass;
   logic [TYPE_BITS-1:0]   rd_type;
   logic [WEIGHT_BITS-1:0] rd_weight;
   status_type             single_stat;

   assign req_op     = opcode_type'(req_tuser);
   assign req_type   = req_tdata[REQ_TYPE_LSB +: TYPE_BITS];
   assign req_weight = req_tdata[REQ_WEIGHT_LSB +: WEIGHT_BITS];
   assign req_chance = req_tdata[REQ_CHANCE_LSB +: CHANCE_W];
   assign req_draw   = req_tdata[REQ_DRAW_LSB +: DRAW_W];

   assign rd_type   = types_ff[idx_ff[IDX_BITS-1:0]];
   assign rd_weight = weights_ff[idx_ff[IDX_BITS-1:0]];

   assign roll_pass = (req_chance < pct_ff) && (count_ff != '0) && (req_draw < sum_ff);

   assign dp_status.walk_needed = (req_op == OP_REMOVE) || ((req_op == OP_ROLL) && roll_pass);
   assign dp_status.walk_done   = (idx_ff == count_ff) || hit_ff;

   always_comb begin
      pct_in       = csr_wen ? csr_wdata : pct_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      op_in        = op_ff;
      type_in      = type_ff;
      draw_in      = draw_ff;
      idx_in       = idx_ff;
      keep_in      = keep_ff;
      acc_in       = acc_ff;
      newsum_in    = newsum_ff;
      hit_in       = hit_ff;
      hit_type_in  = hit_type_ff;
      drop_in      = drop_ff;
      out_type_in  = out_type_ff;
      out_stat_in  = out_stat_ff;
      out_count_in = out_count_ff;
      out_sum_in   = out_sum_ff;
      wr_en        = 1'b0;
      wr_idx       = count_ff[IDX_BITS-1:0];
      wr_type      = req_type;
      wr_weight    = req_weight;
      single_stat  = STAT_DONE;

      if (cmd.accept) begin
         op_in       = req_op;
         type_in     = req_type;
         draw_in     = req_draw;
         idx_in      = '0;
         keep_in     = '0;
         acc_in      = '0;
         newsum_in   = '0;
         hit_in      = 1'b0;
         hit_type_in = '0;
         case (req_op)
            OP_ADD: begin
               if (req_weight == '0) begin
                  single_stat = STAT_ZERO;
               end else if (count_ff >= COUNT_BITS'(MAX_ENTRIES)) begin
                  single_stat = STAT_FULL;
               end else begin
                  wr_en    = 1'b1;
                  count_in = count_ff + COUNT_BITS'(1);
                  sum_in   = sat_add(sum_ff, req_weight);
               end
            end
            OP_CLEAR: begin
               count_in = '0;
               sum_in   = '0;
            end
            OP_ROLL: begin
               single_stat = STAT_NODROP;
            end
            default: begin
               single_stat = STAT_DONE;
            end
         endcase
      end

      if (cmd.step) begin
         idx_in = idx_ff + COUNT_BITS'(1);
         if (op_ff == OP_REMOVE) begin
            if (rd_type != type_ff) begin
               // compact in place: the keep slot never runs ahead of the read slot
               wr_en     = 1'b1;
               wr_idx    = keep_ff[IDX_BITS-1:0];
               wr_type   = rd_type;
               wr_weight = rd_weight;
               keep_in   = keep_ff + COUNT_BITS'(1);
               newsum_in = sat_add(newsum_ff, rd_weight);
            end
         end else begin
            acc_in = acc_ff + ACC_W'(rd_weight);
            if (CMP_W'(draw_ff) < CMP_W'(acc_in)) begin
               hit_in      = 1'b1;
               hit_type_in = rd_type;
            end
         end
      end

      if (cmd.finish && (op_ff == OP_REMOVE)) begin
         count_in = keep_ff;
         sum_in   = newsum_ff;
      end

      if (cmd.load_rsp) begin
         out_count_in = count_in;
         out_sum_in   = sum_in;
         if (cmd.finish) begin
            drop_in     = hit_ff && (op_ff == OP_ROLL);
            out_type_in = (hit_ff && (op_ff == OP_ROLL)) ? hit_type_ff : '0;
            out_stat_in = (op_ff == OP_REMOVE) ? STAT_DONE :
                          (hit_ff ? STAT_DONE : STAT_NODROP);
         end else begin
            drop_in     = 1'b0;
            out_type_in = '0;
            out_stat_in = single_stat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         types_ff[wr_idx]   <= wr_type;
         weights_ff[wr_idx] <= wr_weight;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= '0;
         pct_ff   <= PCT_RESET;
      end else begin
         count_ff <= count_in;
         sum_ff   <= sum_in;
         pct_ff   <= pct_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      type_ff      <= type_in;
      draw_ff      <= draw_in;
      idx_ff       <= idx_in;
      keep_ff      <= keep_in;
      acc_ff       <= acc_in;
      newsum_ff    <= newsum_in;
      hit_ff       <= hit_in;
      hit_type_ff  <= hit_type_in;
      drop_ff      <= drop_in;
      out_type_ff  <= out_type_in;
      out_stat_ff  <= out_stat_in;
      out_count_ff <= out_count_in;
      out_sum_ff   <= out_sum_in;
   end

   always_comb begin
      rsp_tdata = '0;
      rsp_tdata[RSP_DROP_LSB]                  = drop_ff;
      rsp_tdata[RSP_TYPE_LSB +: TYPE_BITS]     = out_type_ff;
      rsp_tdata[RSP_COUNT_LSB +: COUNT_W]      = COUNT_W'(out_count_ff);
      rsp_tdata[RSP_SUM_LSB +: SUM_W]          = out_sum_ff;
   end

   assign rsp_tuser = out_stat_ff;

endmodule

### hw/rtl/weighted_random_select_table_unit.sv
// top level of the weighted random selection table unit
//
//   channel   dir   handshake               payload
//   req_*     in    req_tvalid/req_tready    tdata: item_type, weight, chance_draw, weight_draw
//                                            tuser: opcode
//   rsp_*     out   rsp_tvalid/rsp_tready    tdata: dropped, dropped_type, entry_count,
//                                            total_weight; tuser: status
//   csr_*     in    csr_wen                  csr_wdata: drop_chance_percent
//
// add, clear and a roll that fails its entry tests: result registered on the accept edge
// remove: the table walk reads every stored entry, one stored entry per cycle
// roll that walks: the walk stops once the selected entry is found, same one-entry-per-cycle walk
// one request in flight; req_tready is high only when idle and the result register is free
// reset clears count, sum, percent (to 100) and the response valid; no clearing pass
// a stalled response beat holds and blocks the next request
module weighted_random_select_table_unit
   import wrst_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wen,
   input  logic [CHANCE_W-1:0]    csr_wdata,    // drop_chance_percent
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,    // item_type, weight, chance_draw, weight_draw
   input  logic [OPCODE_W-1:0]    req_tuser,    // opcode
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,    // dropped, dropped_type, entry_count, total_weight
   output logic [STATUS_W-1:0]    rsp_tuser     // status
);

   cmd_type       cmd;
   dp_status_type dp_status;

   wrst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .dp_status  (dp_status),
      .cmd        (cmd)
   );

   wrst_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .cmd       (cmd),
      .dp_status (dp_status),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

### hw/rtl/wrst_checker.sv
// port-level checks of the selection table unit and their bind
`include "weighted_random_select_table_unit_assert.svh"

module wrst_checker
   import wrst_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic [STATUS_W-1:0]    rsp_tuser
);

   // stalled response beat holds its payload
   `WRST_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // no new request while the result register is stuck
   `WRST_ASSERT(a_no_accept_on_stall, clock, reset, rsp_tvalid && !rsp_tready |-> !req_tready)

   // a drop always reports done and a nonempty table
   `WRST_ASSERT(a_drop_consistent, clock, reset, rsp_tvalid && rsp_tdata[RSP_DROP_LSB] |-> rsp_tuser == STAT_DONE && rsp_tdata[RSP_COUNT_LSB +: COUNT_W] != '0)

   // reset leaves no response pending
   `WRST_ASSERT_NORST(a_reset_idle, clock, reset |=> !rsp_tvalid)

endmodule

bind weighted_random_select_table_unit wrst_checker u_wrst_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
